FILE: rtl/sfr_pkg.sv
// Shared types, constants and CRC function for the stuffed frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

   // Result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_END    = 2'd1;
   localparam logic [1:0] CSR_ESCAPE = 2'd2;

   // Register reset values
   localparam logic [7:0] START_BYTE_RESET  = 8'h01;
   localparam logic [7:0] END_BYTE_RESET    = 8'h04;
   localparam logic [7:0] ESCAPE_BYTE_RESET = 8'h1B;

   // CRC-16/Modbus constants
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [8:0] frame_length;
      logic       crc_ok;
      logic       overflow;
   } result_type;

   // Feed one byte into a reflected CRC-16, eight bit steps unrolled
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sfr_req_if.sv
// Request channel carrying one received serial byte.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_rsp_if.sv
// Result channel carrying a data byte report or a frame end report.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic [8:0] frame_length;
   logic       crc_ok;
   logic       overflow;

   modport source (output valid, output result_kind, output data_byte, output byte_index,
                   output frame_length, output crc_ok, output overflow, input ready);
   modport sink (input valid, input result_kind, input data_byte, input byte_index,
                 input frame_length, input crc_ok, input overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_out_reg.sv
// Result register between the frame decoder and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module sfr_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load_valid,
   input  wire sfr_pkg::result_type load_data,
   output logic                    load_ready,
   sfr_rsp_if.source               rsp
);
   import sfr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Take a new result when empty or when the current one leaves this cycle
   assign load_ready = !valid_ff || rsp.ready;
   assign valid_in   = load_valid || (valid_ff && !rsp.ready);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload
   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.result_kind  = data_ff.result_kind;
   assign rsp.data_byte    = data_ff.data_byte;
   assign rsp.byte_index   = data_ff.byte_index;
   assign rsp.frame_length = data_ff.frame_length;
   assign rsp.crc_ok       = data_ff.crc_ok;
   assign rsp.overflow     = data_ff.overflow;

endmodule

`default_nettype wire

FILE: rtl/stuffed_frame_receiver_crc16_top.sv
// Top level of the byte-stuffed frame receiver with CRC-16/Modbus check.
// Usage:
//   req carries one received serial byte per request (valid/ready).
//   rsp carries at most one result per request: a stored data byte with its
//   index, or a frame end report with length, CRC match and overflow flag.
//   csr_we/csr_index/csr_wdata write the start, end and escape byte values;
//   write them only while no request is in flight.
// Timing and throughput:
//   A result is registered and appears on rsp in the cycle after its request
//   is accepted. One request is accepted every cycle while req.ready is high;
//   the frame state and an unrolled 8-bit CRC update close on acceptance.
// Reset:
//   Synchronous, active high. Clears the frame state (count, CRC to FFFF,
//   held bytes, escape and overflow flags), empties the result register
//   and restores the control bytes to 01, 04 and 1B.
// Stall:
//   req.ready drops only while a result waits in the result register and
//   rsp.ready is low; requests that give no result still need that slot free.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_frame_receiver_crc16_top #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   sfr_req_if.sink         req,
   sfr_rsp_if.source       rsp,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import sfr_pkg::*;

   localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

   logic [7:0]    start_ff, end_ff, escape_ff;
   logic          esc_ff, esc_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    held0_ff, held0_in, held1_ff, held1_in;
   logic          ovf_ff, ovf_in;

   logic       accept;
   logic       load_valid;
   logic       load_ready;
   result_type load_data;
   logic [7:0] b;
   logic       full;
   logic       two_plus;

   assign b        = req.rx_byte;
   assign accept   = req.valid && load_ready;
   assign req.ready = load_ready;
   assign full     = (count_ff == CW'(MAX_FRAME_BYTES));
   assign two_plus = (count_ff >= CW'(2));

   // Decode one byte: control bytes first, then data
   always_comb begin
      esc_in     = esc_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      ovf_in     = ovf_ff;
      load_valid = 1'b0;
      load_data  = '0;
      priority if (!esc_ff && b == escape_ff) begin
         esc_in = 1'b1;
      end else if (!esc_ff && b == start_ff) begin
         count_in = '0;
         crc_in   = CRC_INIT;
         held0_in = 8'h00;
         held1_in = 8'h00;
         ovf_in   = 1'b0;
      end else if (!esc_ff && b == end_ff) begin
         load_valid             = 1'b1;
         load_data.result_kind  = KIND_END;
         load_data.frame_length = 9'(count_ff);
         load_data.crc_ok       = !ovf_ff && two_plus &&
                                  held0_ff == crc_ff[15:8] && held1_ff == crc_ff[7:0];
         load_data.overflow     = ovf_ff;
      end else if (full) begin
         esc_in = 1'b0;
         ovf_in = 1'b1;
      end else begin
         esc_in = 1'b0;
         if (two_plus) begin
            crc_in = crc_feed(crc_ff, held0_ff);
         end
         held0_in              = held1_ff;
         held1_in              = b;
         count_in              = count_ff + CW'(1);
         load_valid            = 1'b1;
         load_data.result_kind = KIND_DATA;
         load_data.data_byte   = b;
         load_data.byte_index  = 8'(count_ff);
      end
   end

   // Advance frame state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= 1'b0;
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
         held0_ff <= 8'h00;
         held1_ff <= 8'h00;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         esc_ff   <= esc_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Write control byte registers; drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_BYTE_RESET;
         end_ff    <= END_BYTE_RESET;
         escape_ff <= ESCAPE_BYTE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START:  start_ff  <= csr_wdata;
            CSR_END:    end_ff    <= csr_wdata;
            CSR_ESCAPE: escape_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   sfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (accept && load_valid),
      .load_data  (load_data),
      .load_ready (load_ready),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire
